// ===== hw/rtl/owus_pkg.sv =====
// ----------------------------------------------------------------------------
// owus_pkg
// Shared types, codes and helpers of the 1-Wire over UART sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package owus_pkg;

  // Default payload buffer size
  localparam int MaxBytesDef = 16;
  // Largest buffer that the 4-bit load index can reach
  localparam int BufLimit    = 16;

  // Result queue depth (two results per item at most)
  localparam int FifoDepth   = 4;

  // Input operation codes
  localparam logic [1:0] OpStart = 2'd0;
  localparam logic [1:0] OpSlots = 2'd1;
  localparam logic [1:0] OpLoad  = 2'd2;

  // Result kinds
  localparam logic [1:0] KindSlots = 2'd0;
  localparam logic [1:0] KindRead  = 2'd1;
  localparam logic [1:0] KindDone  = 2'd2;
  localparam logic [1:0] KindBusy  = 2'd3;

  // Slot byte values
  localparam logic [7:0] ResetSlot = 8'hF0;
  localparam logic [7:0] SkipRom   = 8'hCC;
  localparam logic [7:0] SlotOne   = 8'hFF;

  // Slot counts
  localparam logic [3:0] SlotsReset = 4'd1;
  localparam logic [3:0] SlotsByte  = 4'd8;

  // Transaction phases
  typedef enum logic [4:0] {
    PhIdle    = 5'b00001,
    PhReset   = 5'b00010,
    PhRom     = 5'b00100,
    PhFunc    = 5'b01000,
    PhPayload = 5'b10000
  } owus_phase_e;

  // One input item
  typedef struct packed {
    logic [1:0]  op;
    logic        direction;
    logic [7:0]  func_cmd;
    logic [4:0]  length;
    logic [63:0] slot_echo;
    logic [3:0]  load_index;
    logic [7:0]  load_value;
  } owus_item_t;

  // One result item
  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  slot_count;
    logic [63:0] slot_data;
    logic        slow_baud;
    logic [7:0]  read_byte;
    logic        devices_present;
    logic        last;
  } owus_result_t;

  // Results produced by one item, pushed into the queue together
  typedef struct packed {
    logic [1:0]   cnt;
    owus_result_t r0;
    owus_result_t r1;
  } owus_push_t;

  // Each data bit becomes one slot byte, LSB first
  function automatic logic [63:0] spread_bits(input logic [7:0] v);
    logic [63:0] s;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s[8*i +: 8] = {8{v[i]}};
    end
    return s;
  endfunction

  // A slot that echoed all ones reads as a one bit
  function automatic logic [7:0] gather_bits(input logic [63:0] echo);
    logic [7:0] v;
    for (int i = 0; i < 8; i++) begin
      v[i] = (echo[8*i +: 8] == SlotOne);
    end
    return v;
  endfunction

endpackage

// ===== hw/rtl/owus_core.sv =====
// ----------------------------------------------------------------------------
// owus_core
// Transaction state, write buffer and result generation for one item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module owus_core #(
  parameter int MaxBytes = owus_pkg::MaxBytesDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 go_i,
  input  owus_pkg::owus_item_t item_i,
  output owus_pkg::owus_push_t push_o
);
  import owus_pkg::*;

  localparam int BufDepth = (MaxBytes < BufLimit) ? MaxBytes : BufLimit;
  localparam int IdxW     = (BufDepth > 1) ? $clog2(BufDepth) : 1;
  localparam logic [4:0] BufDepthW = 5'(BufDepth);
  localparam logic [8:0] MaxBytesW = 9'(MaxBytes);

  owus_phase_e phase_q, phase_d;
  logic        dir_q, dir_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [4:0]  total_q, total_d;
  logic [4:0]  pos_q, pos_d;
  logic        pres_q, pres_d;
  logic [7:0]  wbuf_q [BufDepth];

  logic [7:0]   wr_byte;
  logic [7:0]   pay_byte;
  logic [4:0]   pos_inc;
  owus_result_t r0, r1;
  logic [1:0]   cnt;

  // Current write byte; positions past the buffer read as zero
  assign wr_byte  = (pos_q < BufDepthW) ? wbuf_q[pos_q[IdxW-1:0]] : 8'h00;
  assign pay_byte = dir_q ? wr_byte : SlotOne;
  assign pos_inc  = pos_q + 5'd1;

  // Step of the sequencer
  always_comb begin
    phase_d = phase_q;
    dir_d   = dir_q;
    cmd_d   = cmd_q;
    total_d = total_q;
    pos_d   = pos_q;
    pres_d  = pres_q;
    r0      = '0;
    r1      = '0;
    cnt     = 2'd0;
    if (go_i) begin
      priority if (item_i.op == OpStart) begin
        cnt     = 2'd1;
        r0.last = 1'b1;
        if (phase_q != PhIdle) begin
          r0.kind = KindBusy;
        end else begin
          dir_d   = item_i.direction;
          cmd_d   = item_i.func_cmd;
          total_d = ({4'd0, item_i.length} > MaxBytesW) ? 5'(MaxBytes) : item_i.length;
          pos_d   = 5'd0;
          phase_d = PhReset;
          r0.kind       = KindSlots;
          r0.slot_count = SlotsReset;
          r0.slot_data  = {56'd0, ResetSlot};
          r0.slow_baud  = 1'b1;
        end
      end else if (item_i.op == OpSlots) begin
        unique case (phase_q)
          PhReset: begin
            pres_d  = (item_i.slot_echo[7:0] != ResetSlot);
            cnt     = 2'd1;
            r0.kind = KindSlots;
            r0.slot_count = SlotsByte;
            r0.slot_data  = spread_bits(SkipRom);
            r0.last       = 1'b1;
            phase_d = PhRom;
          end
          PhRom: begin
            cnt     = 2'd1;
            r0.kind = KindSlots;
            r0.slot_count = SlotsByte;
            r0.slot_data  = spread_bits(cmd_q);
            r0.last       = 1'b1;
            phase_d = PhFunc;
          end
          PhFunc: begin
            cnt     = 2'd1;
            r0.last = 1'b1;
            if (total_q == 5'd0) begin
              phase_d = PhIdle;
              r0.kind = KindDone;
            end else begin
              r0.kind       = KindSlots;
              r0.slot_count = SlotsByte;
              r0.slot_data  = spread_bits(pay_byte);
              if (dir_q) begin
                pos_d = pos_inc;
              end
              phase_d = PhPayload;
            end
          end
          PhPayload: begin
            if (!dir_q) begin
              // Read: emit the byte, then done or the next read slots
              cnt          = 2'd2;
              r0.kind      = KindRead;
              r0.read_byte = gather_bits(item_i.slot_echo);
              r1.last      = 1'b1;
              pos_d        = pos_inc;
              if (pos_inc >= total_q) begin
                phase_d = PhIdle;
                r1.kind = KindDone;
              end else begin
                r1.kind       = KindSlots;
                r1.slot_count = SlotsByte;
                r1.slot_data  = spread_bits(SlotOne);
              end
            end else begin
              cnt     = 2'd1;
              r0.last = 1'b1;
              if (pos_q >= total_q) begin
                phase_d = PhIdle;
                r0.kind = KindDone;
              end else begin
                r0.kind       = KindSlots;
                r0.slot_count = SlotsByte;
                r0.slot_data  = spread_bits(wr_byte);
                pos_d         = pos_inc;
              end
            end
          end
          default: begin
            phase_d = PhIdle;
          end
        endcase
      end else begin
        // Loads and unknown ops give no result
        cnt = 2'd0;
      end
    end
    r0.devices_present = pres_d;
    r1.devices_present = pres_d;
  end

  assign push_o.cnt = cnt;
  assign push_o.r0  = r0;
  assign push_o.r1  = r1;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      dir_q   <= 1'b0;
      cmd_q   <= 8'h00;
      total_q <= 5'd0;
      pos_q   <= 5'd0;
      pres_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      dir_q   <= dir_d;
      cmd_q   <= cmd_d;
      total_q <= total_d;
      pos_q   <= pos_d;
      pres_q  <= pres_d;
    end
  end

  // Write buffer, no reset
  always_ff @(posedge clk_i) begin
    if (go_i && item_i.op == OpLoad && {1'b0, item_i.load_index} < BufDepthW) begin
      wbuf_q[item_i.load_index[IdxW-1:0]] <= item_i.load_value;
    end
  end

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= total_q)
    else $error("payload position beyond transfer length");

  a_idle_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhIdle |-> pos_q == total_q)
    else $error("idle with payload left over");

  a_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.cnt == 2'd2 |-> push_o.r0.kind == KindRead && !push_o.r0.last
                           && push_o.r1.last)
    else $error("bad result pair");

endmodule

// ===== hw/rtl/owus_res_fifo.sv =====
// ----------------------------------------------------------------------------
// owus_res_fifo
// Result queue: takes up to two results a cycle, hands out one when popped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module owus_res_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  owus_pkg::owus_push_t   push_i,
  input  logic                   pop_i,
  output logic                   room_two_o,
  output logic                   valid_o,
  output owus_pkg::owus_result_t head_o
);
  import owus_pkg::*;

  localparam int PtrW = $clog2(FifoDepth);
  localparam int CntW = $clog2(FifoDepth + 1);

  owus_result_t    mem_q [FifoDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic [PtrW-1:0] wr_next;

  assign wr_next    = wr_q + PtrW'(1);
  assign valid_o    = (cnt_q != '0);
  assign head_o     = mem_q[rd_q];
  assign room_two_o = (cnt_q <= CntW'(FifoDepth - 2));

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + PtrW'(push_i.cnt);
      if (pop_i) begin
        rd_q <= rd_q + PtrW'(1);
      end
      cnt_q <= cnt_q + CntW'(push_i.cnt) - CntW'(pop_i);
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_next] <= push_i.r1;
    end
  end

  a_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(FifoDepth))
    else $error("result queue overflow");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.cnt != 2'd0 |-> room_two_o)
    else $error("push without room");

  a_empty_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == '0 |-> wr_q == rd_q && !pop_i)
    else $error("empty queue pointer mismatch");

endmodule

// ===== hw/rtl/onewire_uart_transaction_sequencer.sv =====
// ----------------------------------------------------------------------------
// onewire_uart_transaction_sequencer
// Path: input register, then a four-entry result queue holding the results.
// Throughput: one item per cycle while the queue has room for two results;
// items give up to two; the output hands out one per cycle unless stalled.
// Reset: asynchronous, active low; the sequencer returns to idle and the
// queue empties. Write buffer contents are undefined until loaded.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module onewire_uart_transaction_sequencer #(
  parameter int MaxBytes = owus_pkg::MaxBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input items
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic        direction_i,
  input  logic [7:0]  func_cmd_i,
  input  logic [4:0]  length_i,
  input  logic [63:0] slot_echo_i,
  input  logic [3:0]  load_index_i,
  input  logic [7:0]  load_value_i,
  // Result items
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [3:0]  slot_count_o,
  output logic [63:0] slot_data_o,
  output logic        slow_baud_o,
  output logic [7:0]  read_byte_o,
  output logic        devices_present_o,
  output logic        last_o
);
  import owus_pkg::*;

  logic         in_vld_q;
  owus_item_t   item_q;
  logic         room_two;
  logic         go;
  owus_push_t   push;
  owus_result_t head;

  // Item advances when the queue can take two results
  assign go         = in_vld_q && room_two;
  assign in_stall_o = in_vld_q && !room_two;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_vld_q <= 1'b1;
    end else if (go) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q.op         <= op_i;
      item_q.direction  <= direction_i;
      item_q.func_cmd   <= func_cmd_i;
      item_q.length     <= length_i;
      item_q.slot_echo  <= slot_echo_i;
      item_q.load_index <= load_index_i;
      item_q.load_value <= load_value_i;
    end
  end

  owus_core #(
    .MaxBytes(MaxBytes)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (go),
    .item_i (item_q),
    .push_o (push)
  );

  owus_res_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .pop_i      (out_valid_o && !out_stall_i),
    .room_two_o (room_two),
    .valid_o    (out_valid_o),
    .head_o     (head)
  );

  assign kind_o            = head.kind;
  assign slot_count_o      = head.slot_count;
  assign slot_data_o       = head.slot_data;
  assign slow_baud_o       = head.slow_baud;
  assign read_byte_o       = head.read_byte;
  assign devices_present_o = head.devices_present;
  assign last_o            = head.last;

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_vld_q && !room_two)
    else $error("stall without a held item");

  a_result_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go && push.cnt != 2'd0 |=> out_valid_o)
    else $error("result not presented");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("stall with empty result queue");

endmodule
